[hw/rtl/mwm_pkg.sv]
// Shared types and constants for the Microwire master register block.
package mwm_pkg;

    // Register numbers (byte offset divided by four).
    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_CTRL   = 3'd1;
    localparam logic [2:0] REG_SETUP1 = 3'd2;
    localparam logic [2:0] REG_SETUP2 = 3'd3;
    localparam logic [2:0] REG_SETUP3 = 3'd4;
    localparam logic [2:0] REG_SETUP4 = 3'd5;
    localparam logic [2:0] REG_SETUP5 = 3'd6;
    localparam logic [2:0] REG_NONE   = 3'd7;

    localparam logic       ACT_BUS  = 1'b0;
    localparam logic       ACT_TICK = 1'b1;

    localparam logic [2:0] BUS_SIZE = 3'd2;

    // Control/status bits.
    localparam logic [15:0] CS_READY   = 16'h8000;
    localparam logic [15:0] CS_PENDING = 16'h4000;
    localparam logic [15:0] CS_START   = 16'h2000;
    localparam logic [15:0] CS_WMASK   = 16'h3fff;
    localparam int          CS_LEVEL   = 12;

    localparam logic [4:0]  MAX_TX_BITS = 5'd16;
    localparam int          IRQ_EN_BIT  = 1;

    typedef struct packed {
        logic        action;
        logic        is_write;
        logic [4:0]  offset;
        logic [2:0]  access_size;
        logic [15:0] write_data;
        logic [15:0] rx_word;
    } request_t;

    typedef struct packed {
        logic        bus_ok;
        logic [15:0] read_data;
        logic [3:0]  select_pins;
        logic        transfer_done;
        logic [15:0] tx_word;
        logic [4:0]  tx_bits;
        logic [4:0]  rx_bits;
        logic        tx_irq;
        logic        rx_irq;
    } result_t;

endpackage

[hw/rtl/mwm_core.sv]
// Register bank, chip-select action and transfer logic for one request.
module mwm_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mwm_pkg::request_t req,
    output mwm_pkg::result_t  res
);
    import mwm_pkg::*;

    logic [15:0] data_reg,  data_next;
    logic [15:0] cs_reg,    cs_next;
    logic [5:0]  setup1_reg, setup1_next;
    logic [11:0] setup2_reg, setup2_next;
    logic [2:0]  setup3_reg, setup3_next;
    logic        setup4_reg, setup4_next;
    logic [3:0]  setup5_reg, setup5_next;
    logic [3:0]  sel_reg,   sel_next;

    logic [2:0]  idx;
    logic        ok, wr_ok, rd_ok;
    logic        do_action, changed, transfer, clr_pend;
    logic [15:0] cs_eff;
    logic [3:0]  sel_bit, sel_calc;
    logic [4:0]  ntx, nrx;
    logic [4:0]  shamt;
    logic [15:0] sent, rx_mask;
    logic [15:0] rd;

    always_comb
    begin
        idx   = req.offset[4:2];
        ok    = (req.action == ACT_BUS) && (req.access_size == BUS_SIZE)
                && (req.offset[1:0] == 2'b00) && (idx != REG_NONE);
        wr_ok = ok && req.is_write;
        rd_ok = ok && !req.is_write;

        // A control write lands first, then the select action works on it.
        if (wr_ok && idx == REG_CTRL)
            cs_eff = (cs_reg & CS_READY) | (req.write_data & CS_WMASK) | CS_PENDING;
        else
            cs_eff = cs_reg;

        do_action = (req.action == ACT_TICK) ? ((cs_reg & CS_PENDING) != 16'h0)
                                             : (wr_ok && idx == REG_CTRL);

        sel_bit  = 4'b0001 << cs_eff[11:10];
        sel_calc = cs_eff[CS_LEVEL] ? (sel_reg | sel_bit) : (sel_reg & ~sel_bit);
        changed  = do_action && (sel_calc != sel_reg);
        transfer = do_action && !changed && ((cs_eff & CS_START) != 16'h0);
        clr_pend = do_action && !changed && ((cs_eff & CS_START) == 16'h0);

        nrx = cs_eff[4:0];
        ntx = (cs_eff[9:5] > MAX_TX_BITS) ? MAX_TX_BITS : cs_eff[9:5];
        shamt = MAX_TX_BITS - ntx;
        sent  = (ntx == 5'd0) ? 16'h0 : (data_reg >> shamt[3:0]);
        rx_mask = nrx[4] ? 16'hffff : ~(16'hffff << nrx[3:0]);

        sel_next = changed ? sel_calc : sel_reg;

        if (transfer)
            data_next = req.rx_word & rx_mask;
        else if (wr_ok && idx == REG_DATA)
            data_next = req.write_data;
        else
            data_next = data_reg;

        if (transfer)
            cs_next = (cs_eff | CS_READY) & ~CS_START;
        else if (clr_pend)
            cs_next = cs_eff & ~CS_PENDING;
        else if (rd_ok && idx == REG_DATA)
            cs_next = cs_reg & ~CS_READY;
        else
            cs_next = cs_eff;

        setup1_next = (wr_ok && idx == REG_SETUP1) ? req.write_data[5:0]  : setup1_reg;
        setup2_next = (wr_ok && idx == REG_SETUP2) ? {req.write_data[11:6], 6'b0}
                                                   : setup2_reg;
        setup3_next = (wr_ok && idx == REG_SETUP3) ? req.write_data[2:0]  : setup3_reg;
        setup4_next = (wr_ok && idx == REG_SETUP4) ? req.write_data[0]    : setup4_reg;
        setup5_next = (wr_ok && idx == REG_SETUP5) ? req.write_data[3:0]  : setup5_reg;

        rd = 16'h0;
        if (rd_ok)
        begin
            unique case (idx)
                REG_DATA:   rd = data_reg;
                REG_CTRL:   rd = cs_reg;
                REG_SETUP1: rd = {10'h0, setup1_reg};
                REG_SETUP2: rd = {4'h0, setup2_reg};
                REG_SETUP3: rd = {13'h0, setup3_reg};
                REG_SETUP4: rd = {15'h0, setup4_reg};
                REG_SETUP5: rd = {12'h0, setup5_reg};
                default:    rd = 16'h0;
            endcase
        end

        res.bus_ok        = ok;
        res.read_data     = rd;
        res.select_pins   = sel_next;
        res.transfer_done = transfer;
        res.tx_word       = transfer ? sent : 16'h0;
        res.tx_bits       = transfer ? ntx : 5'd0;
        res.rx_bits       = transfer ? nrx : 5'd0;
        res.tx_irq        = transfer && setup5_reg[IRQ_EN_BIT] && (ntx != 5'd0);
        res.rx_irq        = transfer && setup5_reg[IRQ_EN_BIT] && (nrx != 5'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg   <= '0;
            cs_reg     <= '0;
            setup1_reg <= '0;
            setup2_reg <= '0;
            setup3_reg <= '0;
            setup4_reg <= 1'b0;
            setup5_reg <= '0;
            sel_reg    <= '0;
        end
        else if (fire)
        begin
            data_reg   <= data_next;
            cs_reg     <= cs_next;
            setup1_reg <= setup1_next;
            setup2_reg <= setup2_next;
            setup3_reg <= setup3_next;
            setup4_reg <= setup4_next;
            setup5_reg <= setup5_next;
            sel_reg    <= sel_next;
        end
    end

endmodule

[hw/rtl/microwire_master_registers.sv]
// Top level of the Microwire master register block: request and result registers.
//
// Usage: each request on the input channel is either a 16-bit bus access to the
// register bank (action 0) or a periodic tick (action 1). rx_word carries the
// word returned by the selected serial devices, used if a transfer runs.
// Every request yields exactly one result on the output channel: bus status,
// read data, the chip-select lines after the request and transfer details.
// Both channels use valid and stall; a request is accepted when valid is high
// and stall is low at a rising clock edge.
// Pipeline: an accepted request is held in the request register, and its result
// is then captured in the result register and shown on the output channel. The
// register bank is updated at the edge the result is captured. Throughput is one
// request per cycle while the receiver does not stall.
// Reset clears the register bank and chip-select state (not the result fields)
// and empties both stages. When the receiver stalls, the result holds and the
// request stage keeps one further request, after which in_stall rises.
module microwire_master_registers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        is_write,
    input  logic [4:0]  offset,
    input  logic [2:0]  access_size,
    input  logic [15:0] write_data,
    input  logic [15:0] rx_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        bus_ok,
    output logic [15:0] read_data,
    output logic [3:0]  select_pins,
    output logic        transfer_done,
    output logic [15:0] tx_word,
    output logic [4:0]  tx_bits,
    output logic [4:0]  rx_bits,
    output logic        tx_irq,
    output logic        rx_irq
);
    import mwm_pkg::*;

    logic     req_valid_reg;
    request_t req_reg;
    logic     res_valid_reg;
    result_t  res_reg;
    result_t  res_comb;
    logic     req_move;
    logic     in_accept;

    assign req_move  = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = req_valid_reg && !req_move;
    assign in_accept = in_valid && !in_stall;

    mwm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (req_move),
        .req   (req_reg),
        .res   (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                req_valid_reg <= 1'b1;
            else if (req_move)
                req_valid_reg <= 1'b0;

            if (req_move)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg.action      <= action;
            req_reg.is_write    <= is_write;
            req_reg.offset      <= offset;
            req_reg.access_size <= access_size;
            req_reg.write_data  <= write_data;
            req_reg.rx_word     <= rx_word;
        end
        if (req_move)
            res_reg <= res_comb;
    end

    assign out_valid     = res_valid_reg;
    assign bus_ok        = res_reg.bus_ok;
    assign read_data     = res_reg.read_data;
    assign select_pins   = res_reg.select_pins;
    assign transfer_done = res_reg.transfer_done;
    assign tx_word       = res_reg.tx_word;
    assign tx_bits       = res_reg.tx_bits;
    assign rx_bits       = res_reg.rx_bits;
    assign tx_irq        = res_reg.tx_irq;
    assign rx_irq        = res_reg.rx_irq;

endmodule
